// ===== rtl/htbc_pkg.sv =====
`timescale 1ns / 1ps

package htbc_pkg;

    localparam int CH_W       = 8;
    localparam int HUE_W      = 8;
    localparam int BND_W      = 9;
    localparam int CNT_W      = 17;
    localparam int SUM_W      = 25;
    localparam int CX_W       = 9;
    localparam int CY_W       = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int DIV_CNT_W  = $clog2(SUM_W);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [HUE_W-1:0] HUE_LOW_RST  = 8'd43;
    localparam logic [HUE_W-1:0] HUE_HIGH_RST = 8'd82;
    localparam logic [BND_W-1:0] SAT_LOW_RST  = 9'd53;
    localparam logic [BND_W-1:0] SAT_HIGH_RST = 9'd185;
    localparam logic [BND_W-1:0] VAL_LOW_RST  = 9'd72;
    localparam logic [BND_W-1:0] VAL_HIGH_RST = 9'd126;
    localparam logic [CNT_W-1:0] MIN_AREA_RST = 17'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_LOW  = 3'd0,
        CFG_HUE_HIGH = 3'd1,
        CFG_SAT_LOW  = 3'd2,
        CFG_SAT_HIGH = 3'd3,
        CFG_VAL_LOW  = 3'd4,
        CFG_VAL_HIGH = 3'd5,
        CFG_MIN_AREA = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic            mask;
        logic            frame_done;
        logic            found;
        logic [CX_W-1:0] center_x;
        logic [CY_W-1:0] center_y;
    } res_t;

    typedef struct packed {
        logic accept;
        logic load_div;
        logic div_step;
        logic push_pix;
        logic push_frame;
    } cmd_t;

    typedef struct packed {
        logic frame_end;
        logic found_now;
        logic skid_full;
    } sts_t;

endpackage

// ===== rtl/htbc_if.sv =====
`timescale 1ns / 1ps

interface htbc_pix_if;
    logic                      valid;
    logic                      ready;
    logic [htbc_pkg::CH_W-1:0] hue;
    logic [htbc_pkg::CH_W-1:0] saturation;
    logic [htbc_pkg::CH_W-1:0] brightness;
    logic                      line_end;
    logic                      frame_end;

    modport source (output valid, hue, saturation, brightness, line_end, frame_end,
                    input ready);
    modport sink (input valid, hue, saturation, brightness, line_end, frame_end,
                  output ready);
endinterface

interface htbc_res_if;
    logic                      valid;
    logic                      ready;
    logic                      mask;
    logic                      frame_done;
    logic                      found;
    logic [htbc_pkg::CX_W-1:0] center_x;
    logic [htbc_pkg::CY_W-1:0] center_y;

    modport source (output valid, mask, frame_done, found, center_x, center_y,
                    input ready);
    modport sink (input valid, mask, frame_done, found, center_x, center_y,
                  output ready);
endinterface

// ===== rtl/htbc_ctrl.sv =====
`timescale 1ns / 1ps

module htbc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pix_valid,
    output logic            pix_ready,
    input  htbc_pkg::sts_t  sts,
    output htbc_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_PUSH = 3'b100
    } state_t;

    state_t                           state_reg, state_next;
    logic [htbc_pkg::DIV_CNT_W-1:0]   step_reg, step_next;
    logic                             div_last;

    assign div_last = (step_reg == htbc_pkg::DIV_CNT_W'(htbc_pkg::SUM_W - 1));

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        pix_ready      = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pix_ready  = !sts.skid_full;
                cmd.accept = pix_ready && pix_valid;
                if (cmd.accept)
                begin
                    if (sts.frame_end && sts.found_now)
                    begin
                        cmd.load_div = 1'b1;
                        step_next    = '0;
                        state_next   = ST_DIV;
                    end
                    else
                    begin
                        cmd.push_pix = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (div_last)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!sts.skid_full)
                begin
                    cmd.push_frame = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== rtl/htbc_dp.sv =====
`timescale 1ns / 1ps

module htbc_dp #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [htbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [htbc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [htbc_pkg::CH_W-1:0]       hue,
    input  logic [htbc_pkg::CH_W-1:0]       saturation,
    input  logic [htbc_pkg::CH_W-1:0]       brightness,
    input  logic                            line_end,
    input  logic                            frame_end,
    input  htbc_pkg::cmd_t                  cmd,
    output htbc_pkg::sts_t                  sts,
    output logic                            res_valid,
    input  logic                            res_ready,
    output htbc_pkg::res_t                  res
);

    localparam int COL_W = $clog2(FRAME_WIDTH);
    localparam int ROW_W = $clog2(FRAME_HEIGHT);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);
    localparam logic [htbc_pkg::SUM_W-1:0] CX_MAX = htbc_pkg::SUM_W'(FRAME_WIDTH - 1);
    localparam logic [htbc_pkg::SUM_W-1:0] CY_MAX = htbc_pkg::SUM_W'(FRAME_HEIGHT - 1);
    localparam int SW = htbc_pkg::SUM_W;
    localparam int CW = htbc_pkg::CNT_W;

    logic [htbc_pkg::HUE_W-1:0] hue_low_reg, hue_high_reg;
    logic [htbc_pkg::BND_W-1:0] sat_low_reg, sat_high_reg, val_low_reg, val_high_reg;
    logic [CW-1:0]              min_area_reg;

    logic [COL_W-1:0] column_reg, column_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CW-1:0]    count_reg, count_upd;
    logic [SW-1:0]    sum_x_reg, sum_x_upd, sum_y_reg, sum_y_upd;
    logic [SW:0]      sum_x_wide, sum_y_wide;
    logic             mask_now;

    logic [SW-1:0]    qx_reg, qx_next, qy_reg, qy_next;
    logic [CW-1:0]    rx_reg, rx_next, ry_reg, ry_next, div_reg;
    logic [CW:0]      rx_sh, ry_sh;
    logic [CW+1:0]    rx_diff, ry_diff;
    logic             pend_mask_reg;
    logic [SW-1:0]    cx_full, cy_full;

    logic             out_valid_reg, skid_valid_reg;
    htbc_pkg::res_t   out_reg, skid_reg, push_data;
    logic             push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_low_reg  <= htbc_pkg::HUE_LOW_RST;
            hue_high_reg <= htbc_pkg::HUE_HIGH_RST;
            sat_low_reg  <= htbc_pkg::SAT_LOW_RST;
            sat_high_reg <= htbc_pkg::SAT_HIGH_RST;
            val_low_reg  <= htbc_pkg::VAL_LOW_RST;
            val_high_reg <= htbc_pkg::VAL_HIGH_RST;
            min_area_reg <= htbc_pkg::MIN_AREA_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                htbc_pkg::CFG_HUE_LOW:  hue_low_reg  <= cfg_data[htbc_pkg::HUE_W-1:0];
                htbc_pkg::CFG_HUE_HIGH: hue_high_reg <= cfg_data[htbc_pkg::HUE_W-1:0];
                htbc_pkg::CFG_SAT_LOW:  sat_low_reg  <= cfg_data[htbc_pkg::BND_W-1:0];
                htbc_pkg::CFG_SAT_HIGH: sat_high_reg <= cfg_data[htbc_pkg::BND_W-1:0];
                htbc_pkg::CFG_VAL_LOW:  val_low_reg  <= cfg_data[htbc_pkg::BND_W-1:0];
                htbc_pkg::CFG_VAL_HIGH: val_high_reg <= cfg_data[htbc_pkg::BND_W-1:0];
                htbc_pkg::CFG_MIN_AREA: min_area_reg <= cfg_data[CW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign mask_now = (hue >= hue_low_reg) && (hue <= hue_high_reg)
                   && ({1'b0, saturation} >= sat_low_reg)
                   && ({1'b0, saturation} <= sat_high_reg)
                   && ({1'b0, brightness} >= val_low_reg)
                   && ({1'b0, brightness} <= val_high_reg);

    always_comb
    begin
        sum_x_wide = {1'b0, sum_x_reg} + (SW + 1)'(column_reg);
        sum_y_wide = {1'b0, sum_y_reg} + (SW + 1)'(row_reg);
        count_upd  = count_reg;
        sum_x_upd  = sum_x_reg;
        sum_y_upd  = sum_y_reg;
        if (mask_now)
        begin
            count_upd = (count_reg == htbc_pkg::CNT_MAX) ? count_reg : count_reg + 1'b1;
            sum_x_upd = sum_x_wide[SW] ? htbc_pkg::SUM_MAX : sum_x_wide[SW-1:0];
            sum_y_upd = sum_y_wide[SW] ? htbc_pkg::SUM_MAX : sum_y_wide[SW-1:0];
        end

        column_next = column_reg;
        row_next    = row_reg;
        if (frame_end)
        begin
            column_next = '0;
            row_next    = '0;
        end
        else if (line_end)
        begin
            column_next = '0;
            if (row_reg < ROW_LAST)
            begin
                row_next = row_reg + 1'b1;
            end
        end
        else if (column_reg < COL_LAST)
        begin
            column_next = column_reg + 1'b1;
        end
    end

    assign sts.frame_end = frame_end;
    assign sts.found_now = (count_upd > min_area_reg);
    assign sts.skid_full = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            if (frame_end)
            begin
                count_reg <= '0;
                sum_x_reg <= '0;
                sum_y_reg <= '0;
            end
            else
            begin
                count_reg <= count_upd;
                sum_x_reg <= sum_x_upd;
                sum_y_reg <= sum_y_upd;
            end
        end
    end

    // Restoring division, one quotient bit per cycle for both centroid axes.
    always_comb
    begin
        rx_sh   = {rx_reg, qx_reg[SW-1]};
        ry_sh   = {ry_reg, qy_reg[SW-1]};
        rx_diff = {1'b0, rx_sh} - {2'b00, div_reg};
        ry_diff = {1'b0, ry_sh} - {2'b00, div_reg};
        rx_next = rx_diff[CW+1] ? rx_sh[CW-1:0] : rx_diff[CW-1:0];
        ry_next = ry_diff[CW+1] ? ry_sh[CW-1:0] : ry_diff[CW-1:0];
        qx_next = {qx_reg[SW-2:0], ~rx_diff[CW+1]};
        qy_next = {qy_reg[SW-2:0], ~ry_diff[CW+1]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_div)
        begin
            qx_reg        <= sum_x_upd;
            qy_reg        <= sum_y_upd;
            rx_reg        <= '0;
            ry_reg        <= '0;
            div_reg       <= count_upd;
            pend_mask_reg <= mask_now;
        end
        else if (cmd.div_step)
        begin
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
        end
    end

    assign cx_full = (qx_reg > CX_MAX) ? CX_MAX : qx_reg;
    assign cy_full = (qy_reg > CY_MAX) ? CY_MAX : qy_reg;

    always_comb
    begin
        push_data = '0;
        if (cmd.push_frame)
        begin
            push_data.mask       = pend_mask_reg;
            push_data.frame_done = 1'b1;
            push_data.found      = 1'b1;
            push_data.center_x   = cx_full[htbc_pkg::CX_W-1:0];
            push_data.center_y   = cy_full[htbc_pkg::CY_W-1:0];
        end
        else
        begin
            push_data.mask       = mask_now;
            push_data.frame_done = frame_end;
        end
    end

    assign push = cmd.push_pix || cmd.push_frame;
    assign pop  = out_valid_reg && res_ready;

    // Output word register with a skid slot behind it; pushes come only when the
    // skid slot is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= push_data;
            end
            else
            begin
                out_reg <= push_data;
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

// ===== rtl/hsv_threshold_blob_centroid_core.sv =====
`timescale 1ns / 1ps

// HSV threshold blob centroid core. Pixels arrive in raster order on the pixel channel, each
// marked with line and frame ends, and every pixel yields exactly one result word carrying
// its mask bit. Pixels stream at one per cycle while the result side keeps up; a result
// register with one skid slot lets one more pixel in while a result waits. A frame-end pixel
// whose mask count exceeds min_area starts a restoring divider that produces one quotient bit
// per cycle for both axes; no further pixel is taken until all divide steps are done and the
// centroid word is pushed. A frame end without a detection is handled like an ordinary pixel.
// The centroid is clamped to the frame. Configuration registers are to be written through
// cfg_we, cfg_index and cfg_data by the user only while idle; the block does not enforce it.
module hsv_threshold_blob_centroid_core #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic                            clk,
    input  logic                            rst_n,
    htbc_pix_if.sink                        pixel,
    htbc_res_if.source                      result,
    input  logic                            cfg_we,
    input  logic [htbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [htbc_pkg::CFG_DATA_W-1:0] cfg_data
);

    htbc_pkg::cmd_t cmd;
    htbc_pkg::sts_t sts;
    htbc_pkg::res_t res;
    logic           pix_ready;

    htbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pixel.valid),
        .pix_ready (pix_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    htbc_dp #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .hue        (pixel.hue),
        .saturation (pixel.saturation),
        .brightness (pixel.brightness),
        .line_end   (pixel.line_end),
        .frame_end  (pixel.frame_end),
        .cmd        (cmd),
        .sts        (sts),
        .res_valid  (result.valid),
        .res_ready  (result.ready),
        .res        (res)
    );

    assign pixel.ready       = pix_ready;
    assign result.mask       = res.mask;
    assign result.frame_done = res.frame_done;
    assign result.found      = res.found;
    assign result.center_x   = res.center_x;
    assign result.center_y   = res.center_y;

endmodule

// ===== rtl/htbc_checker.sv =====
`timescale 1ns / 1ps

module htbc_checker #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic                      res_frame_done,
    input logic                      res_found,
    input logic [htbc_pkg::CX_W-1:0] res_center_x,
    input logic [htbc_pkg::CY_W-1:0] res_center_y
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    a_found_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_found |-> res_frame_done)
        else $error("found set on a word that is not a frame end");

    a_center_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_found |-> (res_center_x == '0) && (res_center_y == '0))
        else $error("centroid nonzero without a detection");

    a_center_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_found |->
            (32'(res_center_x) <= FRAME_WIDTH - 1) && (32'(res_center_y) <= FRAME_HEIGHT - 1))
        else $error("centroid outside the frame");

endmodule

bind hsv_threshold_blob_centroid_core htbc_checker #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
) u_htbc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_frame_done (result.frame_done),
    .res_found      (result.found),
    .res_center_x   (result.center_x),
    .res_center_y   (result.center_y)
);

// ===== verif/hsv_threshold_blob_centroid_core_tb.sv =====
`timescale 1ns / 1ps

module hsv_threshold_blob_centroid_core_tb;

    localparam int FRAME_W = 320;
    localparam int FRAME_H = 240;
    localparam int PIXEL_TARGET = 1450;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_GAP = 18;
    localparam logic [htbc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [htbc_pkg::CNT_W-1:0] FULL_FRAME_AREA = 17'd76800;

    typedef struct packed {
        logic [htbc_pkg::CH_W-1:0] hue;
        logic [htbc_pkg::CH_W-1:0] saturation;
        logic [htbc_pkg::CH_W-1:0] brightness;
        logic                      line_end;
        logic                      frame_end;
    } pixel_word_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [htbc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [htbc_pkg::CFG_DATA_W-1:0] cfg_data;

    htbc_pix_if pix();
    htbc_res_if res();

    hsv_threshold_blob_centroid_core #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pix),
        .result    (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [htbc_pkg::HUE_W-1:0] hue_lo;
    logic [htbc_pkg::HUE_W-1:0] hue_hi;
    logic [htbc_pkg::BND_W-1:0] sat_lo;
    logic [htbc_pkg::BND_W-1:0] sat_hi;
    logic [htbc_pkg::BND_W-1:0] val_lo;
    logic [htbc_pkg::BND_W-1:0] val_hi;
    logic [htbc_pkg::CNT_W-1:0] min_area;

    logic [htbc_pkg::CX_W-1:0]  column;
    logic [htbc_pkg::CY_W-1:0]  row;
    logic [htbc_pkg::CNT_W-1:0] mask_count;
    logic [htbc_pkg::SUM_W-1:0] sum_x;
    logic [htbc_pkg::SUM_W-1:0] sum_y;

    htbc_pkg::res_t pending_results[$];
    int             mismatch_count = 0;
    int             pixels_sent = 0;
    int             cycle_count = 0;
    bit             idle_on = 1'b1;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d words outstanding", $time, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic htbc_pkg::res_t threshold_and_accumulate(input pixel_word_t p);
        htbc_pkg::res_t               r;
        logic                         hit;
        logic [htbc_pkg::CNT_W:0]     cnt_next;
        logic [htbc_pkg::SUM_W:0]     sx_next;
        logic [htbc_pkg::SUM_W:0]     sy_next;
        logic [htbc_pkg::SUM_W-1:0]   qx;
        logic [htbc_pkg::SUM_W-1:0]   qy;
        hit = (p.hue >= hue_lo) && (p.hue <= hue_hi) &&
              ({1'b0, p.saturation} >= sat_lo) && ({1'b0, p.saturation} <= sat_hi) &&
              ({1'b0, p.brightness} >= val_lo) && ({1'b0, p.brightness} <= val_hi);
        r = '0;
        r.mask = hit;
        r.frame_done = p.frame_end;
        if (hit)
        begin
            cnt_next = {1'b0, mask_count} + (htbc_pkg::CNT_W + 1)'(1);
            sx_next = {1'b0, sum_x} + (htbc_pkg::SUM_W + 1)'(column);
            sy_next = {1'b0, sum_y} + (htbc_pkg::SUM_W + 1)'(row);
            mask_count = cnt_next[htbc_pkg::CNT_W] ? htbc_pkg::CNT_MAX
                                                   : cnt_next[htbc_pkg::CNT_W-1:0];
            sum_x = sx_next[htbc_pkg::SUM_W] ? htbc_pkg::SUM_MAX : sx_next[htbc_pkg::SUM_W-1:0];
            sum_y = sy_next[htbc_pkg::SUM_W] ? htbc_pkg::SUM_MAX : sy_next[htbc_pkg::SUM_W-1:0];
        end
        if (p.frame_end)
        begin
            if (mask_count > min_area)
            begin
                qx = sum_x / htbc_pkg::SUM_W'(mask_count);
                qy = sum_y / htbc_pkg::SUM_W'(mask_count);
                if (qx > htbc_pkg::SUM_W'(FRAME_W - 1))
                    qx = htbc_pkg::SUM_W'(FRAME_W - 1);
                if (qy > htbc_pkg::SUM_W'(FRAME_H - 1))
                    qy = htbc_pkg::SUM_W'(FRAME_H - 1);
                r.found = 1'b1;
                r.center_x = qx[htbc_pkg::CX_W-1:0];
                r.center_y = qy[htbc_pkg::CY_W-1:0];
            end
            column = '0;
            row = '0;
            mask_count = '0;
            sum_x = '0;
            sum_y = '0;
        end
        else if (p.line_end)
        begin
            column = '0;
            if (row < htbc_pkg::CY_W'(FRAME_H - 1))
                row = row + 1'b1;
        end
        else if (column < htbc_pkg::CX_W'(FRAME_W - 1))
        begin
            column = column + 1'b1;
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        htbc_pkg::res_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: word expected none, actual mask %0d frame_done %0d found %0d",
                         $time, res.mask, res.frame_done, res.found);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("mask", 32'(want.mask), 32'(res.mask));
                compare_field("frame_done", 32'(want.frame_done), 32'(res.frame_done));
                compare_field("found", 32'(want.found), 32'(res.found));
                compare_field("center_x", 32'(want.center_x), 32'(res.center_x));
                compare_field("center_y", 32'(want.center_y), 32'(res.center_y));
            end
        end
    end

    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
            end
            res.ready <= 1'b1;
        end
    end

    task automatic send_pixel(input pixel_word_t p);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
        end
        pix.valid <= 1'b1;
        pix.hue <= p.hue;
        pix.saturation <= p.saturation;
        pix.brightness <= p.brightness;
        pix.line_end <= p.line_end;
        pix.frame_end <= p.frame_end;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        pending_results.push_back(threshold_and_accumulate(p));
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic send_hsv(input int h, input int s, input int v, input bit le, input bit fe);
        pixel_word_t p;
        p.hue = htbc_pkg::CH_W'(h);
        p.saturation = htbc_pkg::CH_W'(s);
        p.brightness = htbc_pkg::CH_W'(v);
        p.line_end = le;
        p.frame_end = fe;
        send_pixel(p);
    endtask

    task automatic wait_for_results();
        pix.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [htbc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [htbc_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            htbc_pkg::CFG_HUE_LOW:  hue_lo = value[htbc_pkg::HUE_W-1:0];
            htbc_pkg::CFG_HUE_HIGH: hue_hi = value[htbc_pkg::HUE_W-1:0];
            htbc_pkg::CFG_SAT_LOW:  sat_lo = value[htbc_pkg::BND_W-1:0];
            htbc_pkg::CFG_SAT_HIGH: sat_hi = value[htbc_pkg::BND_W-1:0];
            htbc_pkg::CFG_VAL_LOW:  val_lo = value[htbc_pkg::BND_W-1:0];
            htbc_pkg::CFG_VAL_HIGH: val_hi = value[htbc_pkg::BND_W-1:0];
            htbc_pkg::CFG_MIN_AREA: min_area = value[htbc_pkg::CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_bounds(input int hl, input int hh, input int sl, input int sh,
                                input int vl, input int vh, input int area);
        write_reg(htbc_pkg::CFG_HUE_LOW, htbc_pkg::CFG_DATA_W'(hl));
        write_reg(htbc_pkg::CFG_HUE_HIGH, htbc_pkg::CFG_DATA_W'(hh));
        write_reg(htbc_pkg::CFG_SAT_LOW, htbc_pkg::CFG_DATA_W'(sl));
        write_reg(htbc_pkg::CFG_SAT_HIGH, htbc_pkg::CFG_DATA_W'(sh));
        write_reg(htbc_pkg::CFG_VAL_LOW, htbc_pkg::CFG_DATA_W'(vl));
        write_reg(htbc_pkg::CFG_VAL_HIGH, htbc_pkg::CFG_DATA_W'(vh));
        write_reg(htbc_pkg::CFG_MIN_AREA, htbc_pkg::CFG_DATA_W'(area));
    endtask

    function automatic logic [htbc_pkg::CH_W-1:0] pick_channel(input int lo, input int hi,
                                                               input bit hit);
        if (hit && lo <= hi && lo <= 255)
            return htbc_pkg::CH_W'($urandom_range(lo, (hi > 255) ? 255 : hi));
        return htbc_pkg::CH_W'($urandom_range(0, 255));
    endfunction

    task automatic send_frame(input int cols, input int rows, input int hit_pct,
                              input bit broken);
        pixel_word_t p;
        bit          hit;
        bit          last_col;
        for (int y = 0; y < rows; y++)
        begin
            for (int x = 0; x < cols; x++)
            begin
                hit = ($urandom_range(1, 100) <= hit_pct);
                last_col = (x == cols - 1);
                p.hue = pick_channel(int'(hue_lo), int'(hue_hi), hit);
                p.saturation = pick_channel(int'(sat_lo), int'(sat_hi), hit);
                p.brightness = pick_channel(int'(val_lo), int'(val_hi), hit);
                p.line_end = last_col;
                p.frame_end = last_col && (y == rows - 1);
                if (broken)
                begin
                    p.line_end = ($urandom_range(0, 6) == 0);
                    p.frame_end = p.frame_end && ($urandom_range(0, 1) == 1);
                end
                send_pixel(p);
            end
        end
    endtask

    task automatic load_random_bounds();
        int hl;
        int hh;
        int sl;
        int sh;
        int vl;
        int vh;
        int area;
        hl = $urandom_range(0, 90);
        hh = $urandom_range(hl, 180);
        sl = $urandom_range(0, 128);
        sh = $urandom_range(sl, 256);
        vl = $urandom_range(0, 128);
        vh = $urandom_range(vl, 256);
        area = $urandom_range(0, 20);
        case ($urandom_range(0, 9))
            0:
            begin
                hl = 0;
                hh = 180;
                sl = 0;
                sh = 256;
                vl = 0;
                vh = 256;
            end
            1:
            begin
                hl = 180;
                hh = 180;
                sh = 256;
                vh = 256;
            end
            2:
            begin
                sl = 200;
                sh = 100;
            end
            3: area = ($urandom_range(0, 1) == 1) ? int'(htbc_pkg::CNT_MAX)
                                                  : int'(FULL_FRAME_AREA);
            4: area = 0;
            default: ;
        endcase
        write_bounds(hl, hh, sl, sh, vl, vh, area);
    endtask

    // The reset thresholds apply here, with each bound just inside and just outside.
    task automatic test_reset_bounds();
        send_hsv(43, 53, 72, 0, 0);
        send_hsv(82, 185, 126, 0, 0);
        send_hsv(42, 100, 100, 0, 0);
        send_hsv(83, 100, 100, 0, 0);
        send_hsv(60, 52, 100, 0, 0);
        send_hsv(60, 186, 100, 0, 0);
        send_hsv(60, 100, 71, 0, 0);
        send_hsv(60, 100, 127, 0, 0);
        send_hsv(0, 0, 0, 0, 0);
        send_hsv(255, 255, 255, 0, 0);
        send_hsv(60, 100, 100, 1, 1);
        wait_for_results();
    endtask

    task automatic test_area_and_empty_band();
        write_bounds(0, 180, 0, 256, 0, 256, 2);
        write_reg(CFG_UNUSED, 17'd0);
        send_hsv(0, 0, 0, 0, 0);
        send_hsv(180, 255, 255, 1, 0);
        send_hsv(90, 128, 128, 0, 1);
        send_hsv(1, 1, 1, 0, 0);
        send_hsv(181, 0, 0, 0, 0);
        send_hsv(2, 2, 2, 0, 1);
        wait_for_results();
        write_reg(htbc_pkg::CFG_MIN_AREA, 17'd0);
        send_hsv(200, 10, 10, 0, 1);
        wait_for_results();
        write_reg(htbc_pkg::CFG_HUE_LOW, 17'd100);
        write_reg(htbc_pkg::CFG_HUE_HIGH, 17'd50);
        send_hsv(75, 100, 100, 0, 0);
        send_hsv(100, 100, 100, 0, 1);
        wait_for_results();
        write_bounds(0, 180, 0, 256, 0, 256, int'(htbc_pkg::CNT_MAX));
        send_hsv(10, 10, 10, 0, 0);
        send_hsv(20, 20, 20, 0, 1);
        wait_for_results();
    endtask

    task automatic test_column_clamp();
        write_bounds(0, 180, 0, 256, 0, 256, 0);
        send_frame(FRAME_W + 15, 1, 90, 1'b0);
        wait_for_results();
    endtask

    task automatic test_row_clamp();
        send_frame(1, FRAME_H + 5, 80, 1'b0);
        wait_for_results();
    endtask

    task automatic test_mid_frame_pause();
        write_bounds(20, 160, 30, 220, 30, 220, 5);
        send_frame(6, 1, 75, 1'b1);
        wait_for_results();
        send_frame(5, 3, 75, 1'b0);
        wait_for_results();
    endtask

    task automatic test_random_frames();
        while (pixels_sent < PIXEL_TARGET - 120)
        begin
            load_random_bounds();
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 6))
                send_frame($urandom_range(1, 12), $urandom_range(1, 8), 75,
                           $urandom_range(0, 9) == 0);
            wait_for_results();
        end
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        load_random_bounds();
        while (pixels_sent < PIXEL_TARGET)
            send_frame($urandom_range(1, 12), $urandom_range(1, 8), 75, 1'b0);
        wait_for_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = htbc_pkg::CFG_HUE_LOW;
        cfg_data = '0;
        pix.valid = 1'b0;
        pix.hue = '0;
        pix.saturation = '0;
        pix.brightness = '0;
        pix.line_end = 1'b0;
        pix.frame_end = 1'b0;
        hue_lo = htbc_pkg::HUE_LOW_RST;
        hue_hi = htbc_pkg::HUE_HIGH_RST;
        sat_lo = htbc_pkg::SAT_LOW_RST;
        sat_hi = htbc_pkg::SAT_HIGH_RST;
        val_lo = htbc_pkg::VAL_LOW_RST;
        val_hi = htbc_pkg::VAL_HIGH_RST;
        min_area = htbc_pkg::MIN_AREA_RST;
        column = '0;
        row = '0;
        mask_count = '0;
        sum_x = '0;
        sum_y = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_bounds();
        test_area_and_empty_band();
        test_column_clamp();
        test_row_clamp();
        test_mid_frame_pause();
        test_random_frames();
        test_full_rate();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
